@@ src/y86e_pkg.sv @@
// Shared constants, codes and types for the Y86-64 execute stage.
package y86e_pkg;

  localparam int WordBits = 64;

  typedef logic [WordBits-1:0] word_t;

  localparam logic [1:0] StatAok = 2'd0;

  localparam logic [3:0] IcodeNop    = 4'd1;
  localparam logic [3:0] IcodeRrmovq = 4'd2;
  localparam logic [3:0] IcodeIrmovq = 4'd3;
  localparam logic [3:0] IcodeRmmovq = 4'd4;
  localparam logic [3:0] IcodeMrmovq = 4'd5;
  localparam logic [3:0] IcodeOpq    = 4'd6;
  localparam logic [3:0] IcodeJxx    = 4'd7;
  localparam logic [3:0] IcodeCall   = 4'd8;
  localparam logic [3:0] IcodeRet    = 4'd9;
  localparam logic [3:0] IcodePushq  = 4'd10;
  localparam logic [3:0] IcodePopq   = 4'd11;

  localparam logic [3:0] AluAdd = 4'd0;
  localparam logic [3:0] AluSub = 4'd1;
  localparam logic [3:0] AluAnd = 4'd2;
  localparam logic [3:0] AluXor = 4'd3;

  localparam logic [3:0] CondAlways = 4'd0;
  localparam logic [3:0] CondLe     = 4'd1;
  localparam logic [3:0] CondL      = 4'd2;
  localparam logic [3:0] CondE      = 4'd3;
  localparam logic [3:0] CondNe     = 4'd4;
  localparam logic [3:0] CondGe     = 4'd5;
  localparam logic [3:0] CondG      = 4'd6;

  localparam logic [3:0] RegNone = 4'd15;

  // Stack pointer adjustments.
  localparam word_t WordMinus8 = ~word_t'(7);
  localparam word_t WordPlus8  = word_t'(8);

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
  } cc_t;

  localparam cc_t CcReset = '{of: 1'b0, sf: 1'b0, zf: 1'b1};

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] icode;
    logic [3:0] ifun;
    word_t      val_a;
    word_t      val_b;
    word_t      val_c;
    logic [3:0] dst_e;
    logic [3:0] dst_m;
    logic [1:0] mem_status;
    logic [1:0] wb_status;
  } instr_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] icode;
    logic       cond_taken;
    word_t      alu_result;
    word_t      val_a;
    logic [3:0] dst_e;
    logic [3:0] dst_m;
    logic       bubbled;
  } result_t;

endpackage

@@ src/y86e_instr_if.sv @@
// Request channel carrying one instruction's execute-register contents.
interface y86e_instr_if;
  logic        valid;
  logic        ready;
  logic [1:0]  in_status;
  logic [3:0]  in_icode;
  logic [3:0]  in_ifun;
  logic [63:0] in_val_a;
  logic [63:0] in_val_b;
  logic [63:0] in_val_c;
  logic [3:0]  in_dst_e;
  logic [3:0]  in_dst_m;
  logic [1:0]  mem_stage_status;
  logic [1:0]  wb_stage_status;

  modport source (
    output valid, in_status, in_icode, in_ifun, in_val_a, in_val_b, in_val_c,
           in_dst_e, in_dst_m, mem_stage_status, wb_stage_status,
    input  ready
  );

  modport sink (
    input  valid, in_status, in_icode, in_ifun, in_val_a, in_val_b, in_val_c,
           in_dst_e, in_dst_m, mem_stage_status, wb_stage_status,
    output ready
  );
endinterface

@@ src/y86e_result_if.sv @@
// Result channel carrying the execute stage's output for one instruction.
interface y86e_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_status;
  logic [3:0]  out_icode;
  logic        cond_taken;
  logic [63:0] alu_result;
  logic [63:0] out_val_a;
  logic [3:0]  out_dst_e;
  logic [3:0]  out_dst_m;
  logic        bubbled;

  modport source (
    output valid, out_status, out_icode, cond_taken, alu_result, out_val_a,
           out_dst_e, out_dst_m, bubbled,
    input  ready
  );

  modport sink (
    input  valid, out_status, out_icode, cond_taken, alu_result, out_val_a,
           out_dst_e, out_dst_m, bubbled,
    output ready
  );
endinterface

@@ src/y86_execute_stage_unit.sv @@
// Y86-64 execute stage: an input register, the ALU and condition logic, and a
// result register. One instruction is accepted every cycle unless the result
// channel stalls, and its result is loaded into the result register whenever
// that register can advance. A stall on the result channel holds both registers
// and is passed back to the request channel in the same cycle. The condition
// codes are written when an OPq instruction moves from the input register to
// the result register and no later stage reports an exception, so a following
// jump or cmov sees them at once. After reset ZF is set and SF and OF are clear.
module y86_execute_stage_unit (
  input logic          clk,
  input logic          rst,
  y86e_instr_if.sink   instr,
  y86e_result_if.source result
);

  logic              s1_valid;
  y86e_pkg::instr_t  s1;
  logic              out_valid;
  y86e_pkg::result_t out_reg;
  y86e_pkg::result_t out_next;
  y86e_pkg::cc_t     cc;
  y86e_pkg::cc_t     cc_next;
  logic              cc_write;
  logic              advance;

  logic              bubble;
  y86e_pkg::word_t   op_a;
  y86e_pkg::word_t   op_b;
  y86e_pkg::word_t   sum;
  y86e_pkg::word_t   diff;
  y86e_pkg::word_t   alu_r;
  logic              alu_of;
  logic [3:0]        alu_fun;
  logic              lt;
  logic              cond_ok;
  logic              taken;
  logic              sign_a;
  logic              sign_b;

  assign advance     = !out_valid || result.ready;
  assign instr.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
    if (instr.valid && instr.ready) begin
      s1.status     <= instr.in_status;
      s1.icode      <= instr.in_icode;
      s1.ifun       <= instr.in_ifun;
      s1.val_a      <= y86e_pkg::word_t'(instr.in_val_a);
      s1.val_b      <= y86e_pkg::word_t'(instr.in_val_b);
      s1.val_c      <= y86e_pkg::word_t'(instr.in_val_c);
      s1.dst_e      <= instr.in_dst_e;
      s1.dst_m      <= instr.in_dst_m;
      s1.mem_status <= instr.mem_stage_status;
      s1.wb_status  <= instr.wb_stage_status;
    end
  end

  // Operand selection and ALU.
  always_comb begin
    bubble = (s1.mem_status != y86e_pkg::StatAok) || (s1.wb_status != y86e_pkg::StatAok);

    op_a = '0;
    op_b = '0;
    unique case (s1.icode)
      y86e_pkg::IcodeRrmovq: op_a = s1.val_a;
      y86e_pkg::IcodeOpq: begin
        op_a = s1.val_a;
        op_b = s1.val_b;
      end
      y86e_pkg::IcodeIrmovq: op_a = s1.val_c;
      y86e_pkg::IcodeRmmovq, y86e_pkg::IcodeMrmovq: begin
        op_a = s1.val_c;
        op_b = s1.val_b;
      end
      y86e_pkg::IcodeCall, y86e_pkg::IcodePushq: begin
        op_a = y86e_pkg::WordMinus8;
        op_b = s1.val_b;
      end
      y86e_pkg::IcodeRet, y86e_pkg::IcodePopq: begin
        op_a = y86e_pkg::WordPlus8;
        op_b = s1.val_b;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase

    alu_fun = (s1.icode == y86e_pkg::IcodeOpq) ? s1.ifun : y86e_pkg::AluAdd;
    sum     = op_a + op_b;
    diff    = op_b - op_a;
    sign_a  = op_a[y86e_pkg::WordBits-1];
    sign_b  = op_b[y86e_pkg::WordBits-1];

    unique case (alu_fun)
      y86e_pkg::AluAdd: begin
        alu_r  = sum;
        alu_of = (sign_a == sign_b) && (sum[y86e_pkg::WordBits-1] != sign_a);
      end
      y86e_pkg::AluSub: begin
        alu_r  = diff;
        alu_of = (sign_a != sign_b) && (diff[y86e_pkg::WordBits-1] != sign_b);
      end
      y86e_pkg::AluAnd: begin
        alu_r  = op_a & op_b;
        alu_of = 1'b0;
      end
      y86e_pkg::AluXor: begin
        alu_r  = op_a ^ op_b;
        alu_of = 1'b0;
      end
      default: begin
        alu_r  = '0;
        alu_of = 1'b0;
      end
    endcase

    cc_next.zf = (alu_r == '0);
    cc_next.sf = alu_r[y86e_pkg::WordBits-1];
    cc_next.of = alu_of;
    cc_write   = (s1.icode == y86e_pkg::IcodeOpq) && !bubble;
  end

  // Jump and cmov condition from the current condition codes.
  always_comb begin
    lt = cc.sf ^ cc.of;
    unique case (s1.ifun)
      y86e_pkg::CondAlways: cond_ok = 1'b1;
      y86e_pkg::CondLe:     cond_ok = lt || cc.zf;
      y86e_pkg::CondL:      cond_ok = lt;
      y86e_pkg::CondE:      cond_ok = cc.zf;
      y86e_pkg::CondNe:     cond_ok = !cc.zf;
      y86e_pkg::CondGe:     cond_ok = !lt;
      y86e_pkg::CondG:      cond_ok = !lt && !cc.zf;
      default:              cond_ok = 1'b0;
    endcase
    taken = cond_ok &&
            ((s1.icode == y86e_pkg::IcodeRrmovq) || (s1.icode == y86e_pkg::IcodeJxx));
  end

  always_comb begin
    if (bubble) begin
      out_next.status     = y86e_pkg::StatAok;
      out_next.icode      = y86e_pkg::IcodeNop;
      out_next.cond_taken = 1'b0;
      out_next.alu_result = '0;
      out_next.val_a      = '0;
      out_next.dst_e      = y86e_pkg::RegNone;
      out_next.dst_m      = y86e_pkg::RegNone;
      out_next.bubbled    = 1'b1;
    end else begin
      out_next.status     = s1.status;
      out_next.icode      = s1.icode;
      out_next.cond_taken = taken;
      out_next.alu_result = alu_r;
      out_next.val_a      = s1.val_a;
      // An untaken conditional move writes no register.
      out_next.dst_e      = (s1.icode == y86e_pkg::IcodeRrmovq && !taken) ?
                            y86e_pkg::RegNone : s1.dst_e;
      out_next.dst_m      = s1.dst_m;
      out_next.bubbled    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cc        <= y86e_pkg::CcReset;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && advance && cc_write) begin
        cc <= cc_next;
      end
    end
    if (s1_valid && advance) begin
      out_reg <= out_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_status = out_reg.status;
  assign result.out_icode  = out_reg.icode;
  assign result.cond_taken = out_reg.cond_taken;
  assign result.alu_result = 64'(out_reg.alu_result);
  assign result.out_val_a  = 64'(out_reg.val_a);
  assign result.out_dst_e  = out_reg.dst_e;
  assign result.out_dst_m  = out_reg.dst_m;
  assign result.bubbled    = out_reg.bubbled;

endmodule
